@@ sv/extended_tick_wakeup_planner_macros.svh @@
// assertion macros shared by the wakeup planner modules
// no dependencies; included by the files that check their own logic
`ifndef EXTENDED_TICK_WAKEUP_PLANNER_MACROS_SVH
`define EXTENDED_TICK_WAKEUP_PLANNER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ETWP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("etwp check failed");

// next-cycle implication, checked outside reset
`define ETWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("etwp check failed");

`endif

@@ sv/etwp_pkg.sv @@
// shared types and constants of the extended tick wakeup planner
// no dependencies
package etwp_pkg;

  localparam int unsigned TIME_W           = 64;
  localparam int unsigned CFG_W            = 16;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CMP_OUT_W        = 16;
  localparam int unsigned COUNTER_BITS_DEF = 16;
  localparam logic [CFG_W-1:0] NOW_THRESHOLD_RST = 16'd5;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PLAN = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_LOW  = 2'd1,
    CLS_HIGH = 2'd2
  } lat_class_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOW_THRESHOLD = 2'd0,
    CFG_SLEEP_LATENCY = 2'd1,
    CFG_WAKE_LATENCY  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] now_threshold;
    logic [CFG_W-1:0] sleep_latency;
    logic [CFG_W-1:0] wake_latency;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]    now_count;
    lat_class_e           latency_class;
    logic                 wake;
    logic                 compare_armed;
    logic [CMP_OUT_W-1:0] compare_value;
  } res_t;

endpackage

@@ sv/etwp_cfg.sv @@
// configuration registers of the wakeup planner
// depends on etwp_pkg
module etwp_cfg
  import etwp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_NOW_THRESHOLD: cfg_d.now_threshold = cfg_data_i;
        CFG_SLEEP_LATENCY: cfg_d.sleep_latency = cfg_data_i;
        CFG_WAKE_LATENCY:  cfg_d.wake_latency  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.now_threshold <= NOW_THRESHOLD_RST;
      cfg_q.sleep_latency <= '0;
      cfg_q.wake_latency  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/etwp_core.sv @@
// timer state and single-pass tick / wakeup planning logic
// depends on etwp_pkg and the assertion macros header
`include "extended_tick_wakeup_planner_macros.svh"

module etwp_core
  import etwp_pkg::*;
#(
  parameter int unsigned CounterBits = COUNTER_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  op_e               op_i,
  input  logic [TIME_W-1:0] deadline_i,
  input  logic              sleep_veto_i,
  input  cfg_t              cfg_i,
  output res_t              res_o
);

  localparam int unsigned OvfW = TIME_W - CounterBits;
  localparam logic [CounterBits-1:0] CntMax = '1;

  logic [CounterBits-1:0] cnt_q, cnt_d;
  logic [OvfW-1:0]        ovf_q, ovf_d;
  logic [CounterBits-1:0] cmp_q, cmp_d;
  logic                   armed_q, armed_d;

  logic [TIME_W-1:0]      udelta;
  logic [TIME_W-1:0]      early;
  logic [CounterBits-1:0] room;
  logic [CFG_W:0]         lat_sum;
  logic                   fit_low;
  logic                   fit_high;
  lat_class_e             cls;
  logic                   wake;
  logic [CMP_OUT_W-1:0]   cmp_view;

  assign udelta   = deadline_i - {ovf_q, cnt_q};
  assign early    = udelta - TIME_W'(cfg_i.wake_latency);
  assign room     = CntMax - cnt_q;
  assign lat_sum  = {1'b0, cfg_i.sleep_latency} + {1'b0, cfg_i.wake_latency};
  assign fit_low  = (udelta[TIME_W-1:CounterBits] == '0) && (udelta[CounterBits-1:0] <= room);
  assign fit_high = (early[TIME_W-1:CounterBits] == '0) && (early[CounterBits-1:0] <= room);

  always_comb begin
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    cmp_d   = cmp_q;
    armed_d = armed_q;
    cls     = CLS_NONE;
    wake    = 1'b0;
    if (fire_i) begin
      if (op_i == OP_TICK) begin
        if (cnt_q == CntMax) begin
          cnt_d = '0;
          ovf_d = ovf_q + 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
        wake = armed_q && (cnt_d == cmp_q);
      end else begin
        if (udelta[TIME_W-1] || (udelta < TIME_W'(cfg_i.now_threshold))) begin
          armed_d = 1'b0;
          cls     = CLS_NONE;
        end else if ((udelta < TIME_W'(lat_sum)) || sleep_veto_i) begin
          if (fit_low) begin
            cmp_d   = udelta[CounterBits-1:0] + cnt_q;
            armed_d = 1'b1;
          end
          cls = CLS_LOW;
        end else begin
          if (fit_high) begin
            cmp_d   = early[CounterBits-1:0] + cnt_q;
            armed_d = 1'b1;
          end
          cls = CLS_HIGH;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ovf_q   <= '0;
      cmp_q   <= '0;
      armed_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      cmp_q   <= cmp_d;
      armed_q <= armed_d;
    end
  end

  if (CounterBits >= CMP_OUT_W) begin : g_cmp_trunc
    assign cmp_view = cmp_d[CMP_OUT_W-1:0];
  end else begin : g_cmp_ext
    assign cmp_view = {{(CMP_OUT_W - CounterBits){1'b0}}, cmp_d};
  end

  always_comb begin
    res_o.now_count     = {ovf_d, cnt_d};
    res_o.latency_class = cls;
    res_o.wake          = wake;
    res_o.compare_armed = armed_d;
    res_o.compare_value = cmp_view;
  end

  `ETWP_ASSERT_NOW(a_wake_only_on_tick, clk_i, rst_ni, fire_i && wake, op_i == OP_TICK)
  `ETWP_ASSERT_NOW(a_class_only_on_plan, clk_i, rst_ni, fire_i && (cls != CLS_NONE), op_i == OP_PLAN)
  `ETWP_ASSERT_NEXT(a_none_disarms, clk_i, rst_ni, fire_i && (op_i == OP_PLAN) && (cls == CLS_NONE), !armed_q)

endmodule

@@ sv/extended_tick_wakeup_planner.sv @@
// top level of the extended tick wakeup planner: input register, planning stage, result register
// depends on etwp_pkg, etwp_cfg, etwp_core and the assertion macros header
`include "extended_tick_wakeup_planner_macros.svh"

// One item per clock cycle while results are taken as presented: each tick or wakeup request
// is taken into an input register, processed by the counter and planning logic against the
// current time, and its result lands in an output register, so each result passes through the
// input register and then the output register. The planning stage's path is the 64-bit deadline
// minus now subtraction and its compares. While a result waits unaccepted the input register
// still takes one more item, then the input stalls until the result is taken.
// Configuration registers are written through a plain write port with no read-back.
module extended_tick_wakeup_planner
  import etwp_pkg::*;
#(
  parameter int unsigned CounterBits = COUNTER_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [TIME_W-1:0]    deadline_i,
  input  logic                 sleep_veto_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [TIME_W-1:0]    now_count_o,
  output logic [1:0]           latency_class_o,
  output logic                 wake_o,
  output logic                 compare_armed_o,
  output logic [CMP_OUT_W-1:0] compare_value_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t cfg;
  res_t res;

  logic              pipe_valid_q, pipe_valid_d;
  op_e               op_q;
  logic [TIME_W-1:0] deadline_q;
  logic              sleep_veto_q;
  logic              out_valid_q, out_valid_d;
  res_t              res_q;
  logic              advance;
  logic              in_fire;

  assign advance    = pipe_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pipe_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    pipe_valid_d = pipe_valid_q;
    if (in_fire) begin
      pipe_valid_d = 1'b1;
    end else if (advance) begin
      pipe_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pipe_valid_q <= pipe_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // item and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q         <= op_e'(operation_i);
      deadline_q   <= deadline_i;
      sleep_veto_q <= sleep_veto_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  etwp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  etwp_core #(
    .CounterBits (CounterBits)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .op_i         (op_q),
    .deadline_i   (deadline_q),
    .sleep_veto_i (sleep_veto_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  assign out_valid_o     = out_valid_q;
  assign now_count_o     = res_q.now_count;
  assign latency_class_o = res_q.latency_class;
  assign wake_o          = res_q.wake;
  assign compare_armed_o = res_q.compare_armed;
  assign compare_value_o = res_q.compare_value;

  `ETWP_ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, in_fire, pipe_valid_q)
  `ETWP_ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni, advance, out_valid_q)
  `ETWP_ASSERT_NEXT(a_stage_holds_item, clk_i, rst_ni, pipe_valid_q && !advance, pipe_valid_q)

endmodule

@@ bench/etwp_timer_checker.sv @@
// result checker of the extended tick wakeup planner testbench
// tracks the timer state from accepted items and compares every result item
// depends on etwp_pkg
module etwp_timer_checker
  import etwp_pkg::*;
#(
  parameter int unsigned CounterBits = COUNTER_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 operation_i,
  input  logic [TIME_W-1:0]    deadline_i,
  input  logic                 sleep_veto_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [TIME_W-1:0]    now_count_i,
  input  logic [1:0]           latency_class_i,
  input  logic                 wake_i,
  input  logic                 compare_armed_i,
  input  logic [CMP_OUT_W-1:0] compare_value_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CounterBits-1:0] CNT_MAX = '1;

  logic [CounterBits-1:0]        tick_cnt;
  logic [TIME_W-CounterBits-1:0] wrap_cnt;
  logic [CounterBits-1:0]        cmp_reg;
  logic                          cmp_en;
  cfg_t                          timing;
  res_t                          expected_results[$];
  res_t                          want;

  function automatic res_t timer_step(op_e op, logic [TIME_W-1:0] dl, logic blk);
    res_t r;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] room;
    logic [TIME_W-1:0] early;
    logic [CFG_W:0]    lat_sum;
    r = '0;
    r.latency_class = CLS_NONE;
    if (op == OP_TICK) begin
      if (tick_cnt == CNT_MAX) begin
        tick_cnt = '0;
        wrap_cnt = wrap_cnt + 1'b1;
      end else begin
        tick_cnt = tick_cnt + 1'b1;
      end
      r.wake = cmp_en && (tick_cnt == cmp_reg);
    end else begin
      now     = {wrap_cnt, tick_cnt};
      delta   = dl - now;
      room    = TIME_W'(CNT_MAX) - TIME_W'(tick_cnt);
      lat_sum = {1'b0, timing.sleep_latency} + {1'b0, timing.wake_latency};
      if (delta[TIME_W-1] || delta < TIME_W'(timing.now_threshold)) begin
        cmp_en = 1'b0;
        r.latency_class = CLS_NONE;
      end else if (delta < TIME_W'(lat_sum) || blk) begin
        if (delta <= room) begin
          cmp_reg = CounterBits'(delta + TIME_W'(tick_cnt));
          cmp_en  = 1'b1;
        end
        r.latency_class = CLS_LOW;
      end else begin
        early = delta - TIME_W'(timing.wake_latency);
        if (early <= room) begin
          cmp_reg = CounterBits'(early + TIME_W'(tick_cnt));
          cmp_en  = 1'b1;
        end
        r.latency_class = CLS_HIGH;
      end
    end
    r.now_count     = {wrap_cnt, tick_cnt};
    r.compare_armed = cmp_en;
    r.compare_value = CMP_OUT_W'(cmp_reg);
    return r;
  endfunction

  task automatic check_field(string name, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      fail_count_o++;
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_cnt             = '0;
      wrap_cnt             = '0;
      cmp_reg              = '0;
      cmp_en               = 1'b0;
      timing.now_threshold = NOW_THRESHOLD_RST;
      timing.sleep_latency = '0;
      timing.wake_latency  = '0;
      expected_results.delete();
      fail_count_o         = 0;
      outstanding_o        = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_NOW_THRESHOLD: timing.now_threshold = cfg_data_i;
          CFG_SLEEP_LATENCY: timing.sleep_latency = cfg_data_i;
          CFG_WAKE_LATENCY:  timing.wake_latency  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $display("%0t unexpected result item: expected none, actual now_count %0h",
                   $time, now_count_i);
        end else begin
          want = expected_results.pop_front();
          check_field("now_count", want.now_count, now_count_i);
          check_field("latency_class", TIME_W'(want.latency_class), TIME_W'(latency_class_i));
          check_field("wake", TIME_W'(want.wake), TIME_W'(wake_i));
          check_field("compare_armed", TIME_W'(want.compare_armed), TIME_W'(compare_armed_i));
          check_field("compare_value", TIME_W'(want.compare_value), TIME_W'(compare_value_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(timer_step(op_e'(operation_i), deadline_i, sleep_veto_i));
      end
      outstanding_o = expected_results.size();
    end
  end

endmodule

@@ bench/extended_tick_wakeup_planner_tb.sv @@
// testbench top of the extended tick wakeup planner: clock, reset, stimulus and verdict
// depends on etwp_pkg, extended_tick_wakeup_planner and etwp_timer_checker
module extended_tick_wakeup_planner_tb;
  import etwp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int unsigned SETTLE_CYCLES    = 6;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned BURST_TICKS      = 60;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  op_e                  operation = OP_TICK;
  logic [TIME_W-1:0]    deadline = '0;
  logic                 sleep_veto = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [TIME_W-1:0]    now_count;
  logic [1:0]           latency_class;
  logic                 wake;
  logic                 compare_armed;
  logic [CMP_OUT_W-1:0] compare_value;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  int unsigned          fail_count;
  int unsigned          outstanding;

  logic              quiet = 1'b0;
  logic              long_hold = 1'b0;
  logic [TIME_W-1:0] tick_total = '0;
  logic [CFG_W-1:0]  thr_s = NOW_THRESHOLD_RST;
  logic [CFG_W-1:0]  slp_s = '0;
  logic [CFG_W-1:0]  wk_s = '0;
  int unsigned       plans_sent = 0;
  int unsigned       settings = 1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  extended_tick_wakeup_planner dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .operation_i     (operation),
    .deadline_i      (deadline),
    .sleep_veto_i    (sleep_veto),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .now_count_o     (now_count),
    .latency_class_o (latency_class),
    .wake_o          (wake),
    .compare_armed_o (compare_armed),
    .compare_value_o (compare_value),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  etwp_timer_checker timer_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .operation_i     (operation),
    .deadline_i      (deadline),
    .sleep_veto_i    (sleep_veto),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .now_count_i     (now_count),
    .latency_class_i (latency_class),
    .wake_i          (wake),
    .compare_armed_i (compare_armed),
    .compare_value_i (compare_value),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  task automatic send_item(input op_e op, input logic [TIME_W-1:0] dl, input logic blk);
    int unsigned gap;
    logic        taken;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    deadline   <= dl;
    sleep_veto <= blk;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    if (op == OP_TICK) tick_total++;
    else plans_sent++;
  endtask

  task automatic settle();
    int unsigned left;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      left = outstanding;
    end while (left != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] thr, slp, wk);
    write_cfg(CFG_NOW_THRESHOLD, thr);
    write_cfg(CFG_SLEEP_LATENCY, slp);
    write_cfg(CFG_WAKE_LATENCY, wk);
    write_cfg(CFG_IDX_SPARE, CFG_W'($urandom));
    thr_s = thr;
    slp_s = slp;
    wk_s  = wk;
    settings++;
  endtask

  // deadlines aimed at the class boundaries and the end of the counter
  function automatic logic [TIME_W-1:0] pick_deadline(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] room;
    room = TIME_W'(16'hFFFF - now[15:0]);
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return now - TIME_W'($urandom_range(1, 200));
      2: return now + TIME_W'($urandom_range(0, 2 * thr_s + 2));
      3: return now + TIME_W'(slp_s) + TIME_W'(wk_s) + TIME_W'($urandom_range(0, 6)) - 64'd3;
      4: return now + room + TIME_W'(wk_s) + TIME_W'($urandom_range(0, 2)) - 64'd1;
      default: return now + TIME_W'(thr_s) + TIME_W'(wk_s) + TIME_W'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic random_phase(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      quiet = (i % 50) < 10;
      if ($urandom_range(0, 99) < 65) begin
        send_item(OP_TICK, {$urandom, $urandom}, 1'($urandom));
      end else begin
        send_item(OP_PLAN, pick_deadline(tick_total), $urandom_range(0, 3) == 0);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin : receiver
    int unsigned stall;
    logic        seen;
    logic        hold_done;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        stall = 0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 7);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        seen = out_valid;
        @(posedge clk);
      end while (!seen);
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing: threshold 5, no latencies
    send_item(OP_TICK, '1, 1'b1);
    send_item(OP_PLAN, 64'd0, 1'b0);
    send_item(OP_PLAN, tick_total, 1'b0);
    send_item(OP_PLAN, tick_total + 64'd4, 1'b0);
    send_item(OP_PLAN, tick_total + 64'd5, 1'b1);
    send_item(OP_PLAN, tick_total + 64'd5, 1'b0);
    repeat (6) send_item(OP_TICK, 64'd0, 1'b0);
    send_item(OP_PLAN, '1, 1'b0);
    send_item(OP_PLAN, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(OP_PLAN, tick_total + TIME_W'(16'hFFFF - tick_total[15:0]), 1'b0);
    send_item(OP_PLAN, tick_total + TIME_W'(16'hFFFF - tick_total[15:0]) + 64'd1, 1'b1);
    send_item(OP_PLAN, 64'h8000_0000_0000_0000, 1'b1);
    settle();

    set_timing('0, '0, '0);
    send_item(OP_PLAN, tick_total, 1'b0);
    random_phase(100);
    settle();

    set_timing('0, '0, 16'd10);
    send_item(OP_PLAN, tick_total + 64'd10, 1'b0);
    send_item(OP_PLAN, tick_total + 64'd9, 1'b0);
    repeat (9) send_item(OP_TICK, '1, 1'b0);
    random_phase(60);
    settle();

    set_timing('1, '1, '1);
    random_phase(80);
    settle();

    // arm once, then run ticks at full rate past the compare value
    set_timing(16'd2, 16'd10, 16'd3);
    send_item(OP_PLAN, tick_total + 64'd50, 1'b0);
    quiet = 1'b1;
    repeat (BURST_TICKS) send_item(OP_TICK, {$urandom, $urandom}, 1'($urandom));
    quiet = 1'b0;
    settle();

    for (int unsigned k = 0; k < 4; k++) begin
      set_timing(CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(0, 300)),
                 CFG_W'($urandom_range(0, 200)));
      if (k == 1) long_hold = 1'b1;
      random_phase(70);
      settle();
    end

    $display("ran %0d ticks and %0d wakeup requests under %0d timing settings",
             tick_total, plans_sent, settings);
    $display("full-rate tick burst past an armed compare and one long output stall included");
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ extended_tick_wakeup_planner.f @@
+incdir+sv
sv/etwp_pkg.sv
sv/etwp_cfg.sv
sv/etwp_core.sv
sv/extended_tick_wakeup_planner.sv
bench/etwp_timer_checker.sv
bench/extended_tick_wakeup_planner_tb.sv
